>>> rtl/sd_block_read_mbr_parser_macros.svh
// Assertion macros shared by the SD block-read MBR parser RTL.
// Included by the files that check their own control logic; needs no package.
`ifndef SD_BLOCK_READ_MBR_PARSER_MACROS_SVH
`define SD_BLOCK_READ_MBR_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define SDMBR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sdmbr assertion failed");
// Check that the consequent holds in the cycle where the antecedent holds.
`define SDMBR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdmbr implication failed");
// Check that the consequent holds in the cycle after the antecedent.
`define SDMBR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdmbr next-cycle check failed");
`else
`define SDMBR_ASSERT(label, clk, rst_n, prop)
`define SDMBR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SDMBR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sdmbr_pkg.sv
// Types and constants of the SD block-read MBR parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package sdmbr_pkg;

    localparam logic [7:0] FILL_BYTE   = 8'hFF;
    localparam logic [7:0] START_TOKEN = 8'hFE;
    localparam logic [7:0] R1_ERR_MASK = 8'hFE;
    localparam logic [7:0] SIG_LO      = 8'h55;
    localparam logic [7:0] SIG_HI      = 8'hAA;
    localparam logic [8:0] TAIL_START  = 9'h1BE;
    localparam logic [8:0] BLOCK_LAST  = 9'h1FF;
    localparam int         FIFO_DEPTH  = 4;

    typedef enum logic [1:0] {
        PH_SEEK_R1    = 2'd0,
        PH_SEEK_TOKEN = 2'd1,
        PH_DATA       = 2'd2,
        PH_DONE       = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_R1    = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_ENTRY = 2'd2,
        KIND_NOSIG = 2'd3
    } kind_t;

    // One classified word handed from front to back.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_value;
        logic [8:0] byte_index;
        logic       r1_error;
        logic       final_byte;   // data byte 511: partition report follows
        logic       sig_ok;
    } job_t;

    // Fields of the partition table that reach the results.
    typedef struct packed {
        logic [3:0][7:0]  status;
        logic [3:0][31:0] lba;
        logic [3:0][31:0] count;
    } table_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_value;
        logic [8:0]  byte_index;
        logic        r1_error;
        logic [1:0]  entry_index;
        logic [7:0]  entry_status;
        logic [31:0] start_sector;
        logic [31:0] sector_count;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/sdmbr_fifo.sv
// Short job queue between the front and back parts of the MBR parser.
// Depends on sdmbr_pkg for the job type.
`default_nettype none

module sdmbr_fifo
    import sdmbr_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  wire   aclk,
    input  wire   aresetn,
    input  wire   push,
    input  job_t  push_job,
    input  wire   pop,
    output job_t  head_job,
    output logic  empty,
    output logic  full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == CNT_FULL);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sdmbr_front.sv
// Front part of the MBR parser: accepts card bytes, tracks the read phase,
// captures the partition table and queues jobs. Depends on sdmbr_pkg.
`default_nettype none
`include "sd_block_read_mbr_parser_macros.svh"

module sdmbr_front
    import sdmbr_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,
    input  wire          s_tuser,
    input  wire          fifo_full,
    output logic         push,
    output job_t         push_job,
    input  wire          tbl_release,
    output table_t       tbl
);

    phase_t     phase_reg, phase_next;
    logic [8:0] count_reg, count_next;
    logic       busy_reg, busy_next;
    table_t     tbl_reg;
    logic [7:0] sig_lo_reg;

    phase_t     phase_eff;
    logic       accept;
    logic       tbl_wr;
    logic [6:0] tail_off;
    logic [1:0] ent;
    logic [3:0] pos;

    // Hold off while the queue is full or a partition report still reads the table.
    assign s_tready  = !fifo_full && !busy_reg;
    assign accept    = s_tvalid && s_tready;
    assign phase_eff = s_tuser ? PH_SEEK_R1 : phase_reg;
    assign tbl       = tbl_reg;

    assign tbl_wr   = accept && (phase_eff == PH_DATA) && (count_reg >= TAIL_START);
    assign tail_off = 7'(count_reg - TAIL_START);
    assign ent      = tail_off[5:4];
    assign pos      = tail_off[3:0];

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        push       = 1'b0;
        push_job   = '0;
        if (accept) begin
            phase_next = phase_eff;
            unique case (phase_eff)
                PH_SEEK_R1: begin
                    if (s_tdata != FILL_BYTE) begin
                        push                = 1'b1;
                        push_job.kind       = KIND_R1;
                        push_job.byte_value = s_tdata;
                        push_job.r1_error   = |(s_tdata & R1_ERR_MASK);
                        phase_next          = PH_SEEK_TOKEN;
                    end
                end
                PH_SEEK_TOKEN: begin
                    if (s_tdata == START_TOKEN) begin
                        phase_next = PH_DATA;
                        count_next = '0;
                    end
                end
                PH_DATA: begin
                    push                = 1'b1;
                    push_job.kind       = KIND_DATA;
                    push_job.byte_value = s_tdata;
                    push_job.byte_index = count_reg;
                    if (count_reg == BLOCK_LAST) begin
                        push_job.final_byte = 1'b1;
                        push_job.sig_ok     = (sig_lo_reg == SIG_LO) && (s_tdata == SIG_HI);
                        phase_next          = PH_DONE;
                        count_next          = '0;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
        if (push && push_job.final_byte) begin
            busy_next = 1'b1;
        end else if (tbl_release) begin
            busy_next = 1'b0;
        end else begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SEEK_R1;
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
    end

    // Capture status, LBA and count bytes of each entry, and signature byte 510.
    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            if (tail_off[6]) begin
                if (!tail_off[0]) begin
                    sig_lo_reg <= s_tdata;
                end
            end else if (pos == 4'd0) begin
                tbl_reg.status[ent] <= s_tdata;
            end else if (pos[3] && !pos[2]) begin
                tbl_reg.lba[ent][8*pos[1:0] +: 8] <= s_tdata;
            end else if (pos[3] && pos[2]) begin
                tbl_reg.count[ent][8*pos[1:0] +: 8] <= s_tdata;
            end
        end
    end

    `SDMBR_ASSERT_IMP(a_busy_blocks_input, aclk, aresetn, busy_reg, !s_tready)
    `SDMBR_ASSERT_NXT(a_final_sets_busy, aclk, aresetn, push && push_job.final_byte, busy_reg)
    `SDMBR_ASSERT_NXT(a_last_byte_ends_block, aclk, aresetn,
        accept && (phase_eff == PH_DATA) && (count_reg == BLOCK_LAST),
        (phase_reg == PH_DONE) && (count_reg == '0))

endmodule

`default_nettype wire

>>> rtl/sdmbr_back.sv
// Back part of the MBR parser: drains jobs, expands the partition report
// and drives the registered result channel. Depends on sdmbr_pkg.
`default_nettype none
`include "sd_block_read_mbr_parser_macros.svh"

module sdmbr_back
    import sdmbr_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          fifo_empty,
    input  job_t         head_job,
    output logic         pop,
    input  table_t       tbl,
    output logic         tbl_release,
    output logic         m_tvalid,
    input  wire          m_tready,
    output result_t      res
);

    logic       valid_reg, valid_next;
    logic       exp_reg, exp_next;
    logic       sig_ok_reg, sig_ok_next;
    logic [3:0] mask_reg, mask_next;
    result_t    res_reg, res_next;

    logic       load;
    logic [3:0] nz;
    logic [3:0] rest;
    logic [1:0] idx;

    assign m_tvalid = valid_reg;
    assign res      = res_reg;
    assign load     = !valid_reg || m_tready;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            nz[i] = |tbl.status[i];
        end
        idx = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (mask_reg[i]) begin
                idx = 2'(i);
            end
        end
        rest = mask_reg & ~(4'b0001 << idx);
    end

    always_comb begin
        valid_next  = valid_reg;
        exp_next    = exp_reg;
        sig_ok_next = sig_ok_reg;
        mask_next   = mask_reg;
        res_next    = res_reg;
        pop         = 1'b0;
        tbl_release = 1'b0;
        if (load) begin
            res_next = '0;
            if (exp_reg) begin
                valid_next = 1'b1;
                if (!sig_ok_reg) begin
                    res_next.kind = KIND_NOSIG;
                    res_next.last = 1'b1;
                    exp_next      = 1'b0;
                    tbl_release   = 1'b1;
                end else begin
                    res_next.kind         = KIND_ENTRY;
                    res_next.entry_index  = idx;
                    res_next.entry_status = tbl.status[idx];
                    res_next.start_sector = tbl.lba[idx];
                    res_next.sector_count = tbl.count[idx];
                    res_next.last         = (rest == '0);
                    mask_next             = rest;
                    exp_next              = (rest != '0);
                    tbl_release           = (rest == '0);
                end
            end else if (!fifo_empty) begin
                pop                 = 1'b1;
                valid_next          = 1'b1;
                res_next.kind       = head_job.kind;
                res_next.byte_value = head_job.byte_value;
                res_next.byte_index = head_job.byte_index;
                res_next.r1_error   = head_job.r1_error;
                if (head_job.final_byte) begin
                    if (head_job.sig_ok && (nz == '0)) begin
                        res_next.last = 1'b1;
                        tbl_release   = 1'b1;
                    end else begin
                        exp_next    = 1'b1;
                        sig_ok_next = head_job.sig_ok;
                        mask_next   = nz;
                    end
                end else begin
                    res_next.last = 1'b1;
                end
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            exp_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            exp_reg   <= exp_next;
        end
    end

    always_ff @(posedge aclk) begin
        sig_ok_reg <= sig_ok_next;
        mask_reg   <= mask_next;
        res_reg    <= res_next;
    end

    `SDMBR_ASSERT_IMP(a_expand_has_word, aclk, aresetn, exp_reg, valid_reg)
    `SDMBR_ASSERT_IMP(a_expand_has_entry, aclk, aresetn, exp_reg && sig_ok_reg, mask_reg != '0)
    `SDMBR_ASSERT_NXT(a_release_ends_report, aclk, aresetn, tbl_release,
        !exp_reg && valid_reg && res_reg.last)

endmodule

`default_nettype wire

>>> rtl/sd_block_read_mbr_parser.sv
// Top level of the SD card single-block read parser with MBR partition report.
// Instantiates sdmbr_front, sdmbr_fifo and sdmbr_back; depends on sdmbr_pkg.
//
// Usage:
//   Feed the bytes returned by the card in SPI mode after a single-block read,
//   one word per byte on the s_ channel. Set s_tuser on the first byte after a
//   new command frame; it abandons any block in progress. The m_ channel
//   returns the R1 byte with its error flag, each of the 512 data bytes with
//   its index, and after byte 511 either one word per partition entry with a
//   nonzero status or one no-signature word. m_tlast marks the final word
//   caused by an input byte.
// Throughput:
//   With the queue ahead empty, an accepted byte passes the job queue and then
//   the output register, which drives m_tvalid. One byte per cycle is taken
//   while the queue has room and no report is in progress. After data byte 511
//   input holds until the report of up to four words has read the captured table.
//   The four-entry job queue plus the output register absorb short stalls.
// Reset and stalls:
//   aresetn (synchronous, active low) returns to R1 search with an empty
//   queue. When m_tready is low the output word holds, the queue fills and
//   then s_tready drops; no word is lost or repeated.
`default_nettype none

module sd_block_read_mbr_parser
    import sdmbr_pkg::*;
#(
    parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
    input  wire          aclk,
    input  wire          aresetn,
    // input stream
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,     // [7:0] rx_byte
    input  wire          s_tuser,     // [0] response_start
    // result stream
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [95:0]  m_tdata,     // [7:0] byte_value, [16:8] byte_index,
                                      // [17] r1_error, [19:18] entry_index,
                                      // [27:20] entry_status, [59:28] start_sector,
                                      // [91:60] sector_count, [95:92] zero
    output logic [1:0]   m_tuser,     // [1:0] kind
    output logic         m_tlast
);

    logic    push;
    job_t    push_job;
    logic    pop;
    job_t    head_job;
    logic    fifo_empty;
    logic    fifo_full;
    logic    tbl_release;
    table_t  tbl;
    result_t res;

    // Classify incoming bytes and capture the partition table.
    sdmbr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_job    (push_job),
        .tbl_release (tbl_release),
        .tbl         (tbl)
    );

    // Decouple the two sides.
    sdmbr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (fifo_empty),
        .full     (fifo_full)
    );

    // Expand jobs into result words.
    sdmbr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fifo_empty  (fifo_empty),
        .head_job    (head_job),
        .pop         (pop),
        .tbl         (tbl),
        .tbl_release (tbl_release),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .res         (res)
    );

    // Pack the result word, first field in the lowest bits.
    assign m_tdata = {4'b0000, res.sector_count, res.start_sector, res.entry_status,
                      res.entry_index, res.r1_error, res.byte_index, res.byte_value};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

`default_nettype wire
